// ----- design/rctb_pkg.sv -----
`timescale 1ns / 1ps

package rctb_pkg;

    // Field widths of one peer entry
    localparam int FAMILY_W  = 16;
    localparam int ADDRESS_W = 32;
    localparam int PORT_W    = 16;
    localparam int ENTRY_W   = FAMILY_W + ADDRESS_W + PORT_W;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;

    // Command codes
    localparam logic CMD_DATAGRAM   = 1'b0;
    localparam logic CMD_DISCONNECT = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DEST         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DISC_DONE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DISC_UNKNOWN = 2'd2;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [FAMILY_W-1:0]  family;
        logic [ADDRESS_W-1:0] address;
        logic [PORT_W-1:0]    port;
    } entry_t;

    // Classified request handed from front to back
    typedef struct packed {
        logic                 disc;
        logic [FAMILY_W-1:0]  family;
        logic [ADDRESS_W-1:0] address;
        logic [PORT_W-1:0]    port;
    } req_t;

endpackage

// ----- design/rctb_if.sv -----
`timescale 1ns / 1ps

// Incoming datagram channel
interface rctb_in_if import rctb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [FAMILY_W-1:0]  peer_family;
    logic [ADDRESS_W-1:0] peer_address;
    logic [PORT_W-1:0]    peer_port;

    modport source (output valid, output command, output peer_family,
                    output peer_address, output peer_port, input ready);
    modport sink   (input valid, input command, input peer_family,
                    input peer_address, input peer_port, output ready);
endinterface

// Outgoing result channel
interface rctb_out_if import rctb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [FAMILY_W-1:0]  dest_family;
    logic [ADDRESS_W-1:0] dest_address;
    logic [PORT_W-1:0]    dest_port;
    logic [COUNT_W-1:0]   client_count;
    logic                 last;

    modport source (output valid, output status, output dest_family,
                    output dest_address, output dest_port,
                    output client_count, output last, input ready);
    modport sink   (input valid, input status, input dest_family,
                    input dest_address, input dest_port,
                    input client_count, input last, output ready);
endinterface

// ----- design/rctb_ram.sv -----
`timescale 1ns / 1ps

module rctb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/rctb_front.sv -----
`timescale 1ns / 1ps

module rctb_front import rctb_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    rctb_in_if.sink    datagram,
    output logic       q_valid,
    input  logic       q_ready,
    output req_t       q_req
);

    // Two-entry request queue
    req_t       entries_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push, pop;
    req_t       in_req;

    // Classify the incoming datagram
    always_comb
    begin
        in_req.disc    = (datagram.command == CMD_DISCONNECT);
        in_req.family  = datagram.peer_family;
        in_req.address = datagram.peer_address;
        in_req.port    = datagram.peer_port;
    end

    assign datagram.ready = (fill_reg != 2'd2);
    assign q_valid        = (fill_reg != 2'd0);
    assign q_req          = entries_reg[rd_ptr_reg];
    assign push           = datagram.valid && datagram.ready;
    assign pop            = q_valid && q_ready;

    // Pointer and fill updates
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

// ----- design/rctb_back.sv -----
`timescale 1ns / 1ps

module rctb_back import rctb_pkg::*; #(
    parameter int MAX_CLIENTS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    output logic       q_ready,
    input  req_t       q_req,
    rctb_out_if.source dest
);

    localparam int AW = $clog2(MAX_CLIENTS);
    localparam int CW = $clog2(MAX_CLIENTS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_CLIENTS);
    localparam logic [CW-1:0] ONE     = CW'(1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_DECIDE   = 3'd2;
    localparam logic [2:0] S_SHIFT    = 3'd3;
    localparam logic [2:0] S_APPEND   = 3'd4;
    localparam logic [2:0] S_EMIT_RD  = 3'd5;
    localparam logic [2:0] S_EMIT_LD  = 3'd6;
    localparam logic [2:0] S_DISC_OUT = 3'd7;

    logic [2:0]          state_reg, state_next;
    req_t                cur_reg, cur_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       rd_idx_reg, rd_idx_next;
    logic [CW-1:0]       wr_idx_reg, wr_idx_next;
    logic [CW-1:0]       pos_reg, pos_next;
    logic                pend_reg, pend_next;
    logic                found_reg, found_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    entry_t              out_entry_reg, out_entry_next;
    logic [CW-1:0]       out_count_reg, out_count_next;
    logic                out_last_reg, out_last_next;
    logic                out_load, out_free;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
    entry_t              rd_entry;
    logic                match;

    rctb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_CLIENTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = ram_rdata;
    assign match    = (rd_entry.family == cur_reg.family) &&
                      (rd_entry.address == cur_reg.address);
    assign out_free = !out_valid_reg || dest.ready;

    // Sequencer: scan, shift out the removed or evicted entry, append, emit, or report a disconnect
    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        wr_idx_next     = wr_idx_reg;
        pos_next        = pos_reg;
        pend_next       = pend_reg;
        found_next      = found_reg;
        q_ready         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = wr_idx_reg[AW-1:0];
        ram_wdata       = ram_rdata;
        ram_raddr       = rd_idx_reg[AW-1:0];
        out_load        = 1'b0;
        out_status_next = out_status_reg;
        out_entry_next  = out_entry_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    cur_next    = q_req;
                    found_next  = 1'b0;
                    pend_next   = 1'b0;
                    rd_idx_next = '0;
                    state_next  = (count_reg == '0) ? S_DECIDE : S_SCAN;
                end
            end
            // Compare returned entries, stop at the first match
            S_SCAN:
            begin
                if (pend_reg && match)
                begin
                    found_next = 1'b1;
                    pos_next   = rd_idx_reg - ONE;
                    state_next = S_DECIDE;
                end
                else if (rd_idx_reg == count_reg)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + ONE;
                    pend_next   = 1'b1;
                end
            end
            S_DECIDE:
            begin
                pend_next = 1'b0;
                if (found_reg)
                begin
                    rd_idx_next = pos_reg + ONE;
                    wr_idx_next = pos_reg;
                    state_next  = S_SHIFT;
                end
                else if (!cur_reg.disc && count_reg == MAX_CNT)
                begin
                    // evict the oldest entry
                    rd_idx_next = ONE;
                    wr_idx_next = '0;
                    state_next  = S_SHIFT;
                end
                else if (cur_reg.disc)
                begin
                    state_next = S_DISC_OUT;
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end
            // Move later entries one slot toward the front
            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    ram_we      = 1'b1;
                    wr_idx_next = wr_idx_reg + ONE;
                end
                if (rd_idx_reg < count_reg)
                begin
                    rd_idx_next = rd_idx_reg + ONE;
                    pend_next   = 1'b1;
                end
                else
                begin
                    count_next = count_reg - ONE;
                    state_next = cur_reg.disc ? S_DISC_OUT : S_APPEND;
                end
            end
            S_APPEND:
            begin
                ram_we      = 1'b1;
                ram_waddr   = count_reg[AW-1:0];
                ram_wdata   = {cur_reg.family, cur_reg.address, cur_reg.port};
                count_next  = count_reg + ONE;
                rd_idx_next = '0;
                state_next  = S_EMIT_RD;
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_LD;
            end
            // Hand one destination to the output register
            S_EMIT_LD:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = ST_DEST;
                    out_entry_next  = rd_entry;
                    out_count_next  = count_reg;
                    out_last_next   = (rd_idx_reg == count_reg - ONE);
                    if (rd_idx_reg == count_reg - ONE)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + ONE;
                        state_next  = S_EMIT_RD;
                    end
                end
            end
            S_DISC_OUT:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = found_reg ? ST_DISC_DONE : ST_DISC_UNKNOWN;
                    out_entry_next  = '0;
                    out_count_next  = count_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (dest.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        rd_idx_reg     <= rd_idx_next;
        wr_idx_reg     <= wr_idx_next;
        pos_reg        <= pos_next;
        out_status_reg <= out_status_next;
        out_entry_reg  <= out_entry_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    assign dest.valid        = out_valid_reg;
    assign dest.status       = out_status_reg;
    assign dest.dest_family  = out_entry_reg.family;
    assign dest.dest_address = out_entry_reg.address;
    assign dest.dest_port    = out_entry_reg.port;
    assign dest.client_count = COUNT_W'(out_count_reg);
    assign dest.last         = out_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("entry count above table size");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_SHIFT || state_reg == S_APPEND))
        else $error("table written outside shift or append");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_APPEND |-> count_reg < MAX_CNT)
        else $error("append into a full table");

    a_dest_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == ST_DEST) |-> out_count_reg != '0)
        else $error("destination reported from an empty table");
`endif

endmodule

// ----- design/recency_client_table_broadcast_unit.sv -----
`timescale 1ns / 1ps

// Recency-ordered peer table with broadcast. Entries (family, IPv4 address,
// port) are matched on family and address; a datagram moves its sender to
// the newest slot (evicting the oldest when the table is full and the sender
// is new) and then yields every entry oldest first, the final one marked
// last. A disconnect yields one result: removed or unknown peer. The table
// sits in a single-port-read RAM, so the back end walks it one entry per
// cycle while searching and shifting; a datagram is then appended and each
// destination read and handed on once the output register is free. A search
// that stops early on a match leaves only the later entries to shift. A
// two-deep request queue in front keeps accepting while the back end is
// busy, until it holds two requests.
module recency_client_table_broadcast_unit import rctb_pkg::*; #(
    parameter int MAX_CLIENTS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    rctb_in_if.sink    datagram,
    rctb_out_if.source dest
);

    logic q_valid;
    logic q_ready;
    req_t q_req;

    rctb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .datagram (datagram),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_req    (q_req)
    );

    rctb_back #(
        .MAX_CLIENTS (MAX_CLIENTS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_req   (q_req),
        .dest    (dest)
    );

endmodule
